FILE: hw/rtl/fqt_pkg.sv
// ----------------------------------------------------------------------------
// fqt_pkg
// shared types and constants for the fp32 quantiser with transpose
// ----------------------------------------------------------------------------
package fqt_pkg;

    localparam logic [2:0] REG_SCALE     = 3'd0;
    localparam logic [2:0] REG_NARROW    = 3'd1;
    localparam logic [2:0] REG_TRANSPOSE = 3'd2;
    localparam logic [2:0] REG_ROWS      = 3'd3;
    localparam logic [2:0] REG_COLS      = 3'd4;

    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

    typedef struct packed {
        logic [31:0] scale_bits;
        logic        narrow_mode;
        logic        transpose_on;
        logic [10:0] row_count;
        logic [10:0] column_count;
    } cfg_t;

    // product stage result: exact product as sign, magnitude, exponent
    typedef struct packed {
        logic        nan;
        logic        inf;
        logic        zero;
        logic        sign;
        logic        neg_bias;
        logic [47:0] mant;
        logic signed [10:0] exp2;
        logic        narrow;
    } prod_t;

endpackage

FILE: hw/rtl/fqt_mul.sv
// ----------------------------------------------------------------------------
// fqt_mul
// exact fp32 times fp32 product, unpacked
// ----------------------------------------------------------------------------
module fqt_mul
(
    input  logic [31:0]    a,
    input  logic [31:0]    b,
    input  logic           narrow,
    output fqt_pkg::prod_t p
);

    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [23:0] ma;
    logic [23:0] mb;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;

    always_comb
    begin
        ea = a[30:23];
        eb = b[30:23];
        ma = {(ea != 8'd0), a[22:0]};
        mb = {(eb != 8'd0), b[22:0]};
        a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (ea == 8'd0) && (a[22:0] == 23'd0);
        b_zero = (eb == 8'd0) && (b[22:0] == 23'd0);
        p.nan = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
        p.inf = a_inf || b_inf;
        p.zero = a_zero || b_zero;
        p.sign = a[31] ^ b[31];
        p.neg_bias = a[31] && !a_nan;
        p.mant = ma * mb;
        // value = mant * 2^(exp2), exponents with subnormal fix
        p.exp2 = $signed({3'd0, ((ea == 8'd0) ? 8'd1 : ea)})
               + $signed({3'd0, ((eb == 8'd0) ? 8'd1 : eb)}) - 11'sd300;
        p.narrow = narrow;
    end

endmodule

FILE: hw/rtl/fqt_round.sv
// ----------------------------------------------------------------------------
// fqt_round
// adds the signed half, rounds to fp32, clamps and truncates toward zero
// ----------------------------------------------------------------------------
module fqt_round
(
    input  fqt_pkg::prod_t p,
    output logic [15:0]    q
);

    localparam logic [44:0] HALF = 45'h200_0000;

    // fixed point with 26 fraction bits, integer part below 2^18
    logic [43:0] fx;
    logic [47:0] shr;
    logic        sticky;
    logic        big;
    logic [44:0] mag;
    logic        sneg;
    logic [16:0] ipart;
    logic [25:0] frac;
    logic [4:0]  msb;
    logic [26:0] half;
    logic [26:0] rsum;
    logic [17:0] rpart;
    logic signed [18:0] sv;
    logic signed [18:0] hi;
    logic signed [18:0] lo;
    logic signed [18:0] r;
    logic signed [11:0] sh;

    always_comb
    begin
        // fx = mant * 2^(exp2+26), sticky holds lost bits
        sh = 12'(p.exp2) + 12'sd26;
        big = 1'b0;
        fx = '0;
        shr = '0;
        sticky = 1'b0;
        if (p.zero)
        begin
            fx = '0;
        end
        else if (sh >= 12'sd0)
        begin
            if (sh > 12'sd43 || (p.mant >> (7'd44 - 7'(sh))) != 48'd0)
                big = 1'b1;
            else
                fx = 44'(p.mant << sh);
        end
        else if (sh > -12'sd48)
        begin
            shr = p.mant >> (-sh);
            big = shr[47:44] != 4'd0;
            fx = shr[43:0];
            sticky = (p.mant & ((48'd1 << (-sh)) - 48'd1)) != 48'd0;
        end
        else
        begin
            sticky = 1'b1;
        end
        // magnitude of product plus signed half, floor at the lsb
        if (p.sign == p.neg_bias)
        begin
            mag = {1'b0, fx} + HALF;
            sneg = p.sign;
        end
        else if ({1'b0, fx} >= HALF)
        begin
            mag = {1'b0, fx} - HALF;
            sneg = p.sign;
        end
        else
        begin
            mag = HALF - {1'b0, fx};
            sneg = p.neg_bias;
            if (sticky)
                mag = mag - 45'd1;
        end
        ipart = 17'(mag >> 26);
        frac = mag[25:0];
        msb = 5'd0;
        for (int i = 0; i < 17; i++)
            if (ipart[i])
                msb = 5'(i);
        // fp32 rounding of the sum can carry it up to the next integer
        if (ipart == 17'd0)
            half = 27'd2;
        else
            half = 27'd4 << msb;
        rsum = {1'b0, frac} + half;
        rpart = {1'b0, ipart} + {17'd0, rsum[26]};
        sv = sneg ? -$signed({1'b0, rpart}) : $signed({1'b0, rpart});
        hi = p.narrow ? 19'sd127 : 19'sd32767;
        lo = p.narrow ? -19'sd128 : -19'sd32768;
        if (p.nan)
            r = hi;
        else if (p.inf || big)
            r = p.sign ? lo : hi;
        else if (mag[44:42] != 3'd0)
            r = sneg ? lo : hi;
        else if (sv > hi)
            r = hi;
        else if (sv < lo)
            r = lo;
        else
            r = sv;
        q = r[15:0];
    end

endmodule

FILE: hw/rtl/fp32_quantizer_with_transpose.sv
// ----------------------------------------------------------------------------
// fp32_quantizer_with_transpose
// fp32 to int16/int8 quantiser with row-major or transposed destination index
// ----------------------------------------------------------------------------
// stages: result passes two register stages, the product register then the output register
// throughput: one transaction per cycle while out_ready holds; a stalled output holds both stages
// reset: configuration returns to scale 1.0, int16, no transpose, 1x1 matrix;
// position counters clear, both stages empty
module fp32_quantizer_with_transpose #(
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_COLUMNS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] sample_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [15:0] quantized,
    output logic [19:0] dest_index,
    output logic        last_element
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    fqt_pkg::cfg_t  cfg_reg;
    fqt_pkg::prod_t prod;
    fqt_pkg::prod_t prod_reg;
    logic           s1_valid_reg;
    logic [19:0]    idx_reg;
    logic           last_reg;
    logic [RW-1:0]  row_reg;
    logic [CW-1:0]  col_reg;
    logic [16:0]    rows;
    logic [16:0]    cols;
    logic           row_end;
    logic           last;
    logic [19:0]    idx;
    logic [15:0]    q;
    logic           s1_adv;
    logic           accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_bits   <= fqt_pkg::SCALE_RESET;
            cfg_reg.narrow_mode  <= 1'b0;
            cfg_reg.transpose_on <= 1'b0;
            cfg_reg.row_count    <= 11'd1;
            cfg_reg.column_count <= 11'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fqt_pkg::REG_SCALE:     cfg_reg.scale_bits   <= cfg_data;
                fqt_pkg::REG_NARROW:    cfg_reg.narrow_mode  <= cfg_data[0];
                fqt_pkg::REG_TRANSPOSE: cfg_reg.transpose_on <= cfg_data[0];
                fqt_pkg::REG_ROWS:      cfg_reg.row_count    <= cfg_data[10:0];
                fqt_pkg::REG_COLS:      cfg_reg.column_count <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (cfg_reg.row_count == 11'd0)
            rows = 17'd1;
        else if (17'(cfg_reg.row_count) > 17'(MAX_ROWS))
            rows = 17'(MAX_ROWS);
        else
            rows = 17'(cfg_reg.row_count);
        if (cfg_reg.column_count == 11'd0)
            cols = 17'd1;
        else if (17'(cfg_reg.column_count) > 17'(MAX_COLUMNS))
            cols = 17'(MAX_COLUMNS);
        else
            cols = 17'(cfg_reg.column_count);
        row_end = (17'(col_reg) + 17'd1) >= cols;
        last = row_end && ((17'(row_reg) + 17'd1) >= rows);
        if (cfg_reg.transpose_on)
            idx = 20'(17'(col_reg) * rows + 34'(row_reg));
        else
            idx = 20'(17'(row_reg) * cols + 34'(col_reg));
    end

    fqt_mul u_mul
    (
        .a      (sample_bits),
        .b      (cfg_reg.scale_bits),
        .narrow (cfg_reg.narrow_mode),
        .p      (prod)
    );

    fqt_round u_round
    (
        .p (prod_reg),
        .q (q)
    );

    assign s1_adv   = !out_valid || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last)
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                end
                else if (row_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s1_adv)
                out_valid <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg <= prod;
            idx_reg  <= idx;
            last_reg <= last;
        end
        if (s1_adv && s1_valid_reg)
        begin
            quantized    <= q;
            dest_index   <= idx_reg;
            last_element <= last_reg;
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fp32 quantiser with transpose. A directed set
// of corner values is followed by random phases of scale, int8/int16 mode,
// transpose and matrix shape. Each accepted sample is quantised and indexed
// by a scoreboard predictor, and every result transaction is checked
// against it in order.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [2:0] REG_SPARE = 3'd7;
    localparam logic [2:0] REG_HOLE  = 3'd5;
    localparam int         N_ITEMS   = 1100;

    typedef struct {
        logic signed [15:0] quantized;
        logic [19:0]        dest_index;
        logic               last_element;
    } quant_result_t;

    class quant_scoreboard;
        logic [31:0]   scale_bits = fqt_pkg::SCALE_RESET;
        logic          narrow_mode;
        logic          transpose_on;
        logic [10:0]   row_count = 11'd1;
        logic [10:0]   column_count = 11'd1;
        int            src_row;
        int            src_col;
        int            errors;
        int            lasts;
        quant_result_t expected_q[$];

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                fqt_pkg::REG_SCALE:     scale_bits = data;
                fqt_pkg::REG_NARROW:    narrow_mode = data[0];
                fqt_pkg::REG_TRANSPOSE: transpose_on = data[0];
                fqt_pkg::REG_ROWS:      row_count = data[10:0];
                fqt_pkg::REG_COLS:      column_count = data[10:0];
                default:       ;
            endcase
        endfunction

        function int eff_count(logic [10:0] c);
            if (c == 0)
                return 1;
            return (c > 1024) ? 1024 : int'(c);
        endfunction

        function real fp32_value(logic [31:0] b);
            logic [7:0]  e;
            logic [63:0] d;
            real         r;
            e = b[30:23];
            if (e == 8'hFF)
                d = {b[31], 11'h7FF, b[22:0], 29'b0};
            else if (e == 8'h00)
            begin
                r = real'(b[22:0]) * 2.0 ** (-149);
                return b[31] ? -r : r;
            end
            else
                d = {b[31], {3'b0, e} + 11'd896, b[22:0], 29'b0};
            return $bitstoreal(d);
        endfunction

        function int quantise(real v, real sc, logic narrow);
            real hi, lo, s, a, ulp, q, fl;
            int  e;
            hi = narrow ? 127.0 : 32767.0;
            lo = narrow ? -128.0 : -32768.0;
            s = v * sc + ((v < 0.0) ? -0.5 : 0.5);
            if (!(s < hi))
                s = hi;
            if (s < lo)
                s = lo;
            a = (s < 0.0) ? -s : s;
            if (a < 2.0 ** (-100))
                return 0;
            // round to fp32 precision, nearest even
            e = 15;
            while (2.0 ** e > a)
                e--;
            ulp = 2.0 ** (e - 23);
            q = a / ulp;
            fl = $floor(q);
            if ((q - fl > 0.5) || (q - fl == 0.5 && ($rtoi(fl) % 2) == 1))
                fl = fl + 1.0;
            a = fl * ulp;
            return (s < 0.0) ? -$rtoi(a) : $rtoi(a);
        endfunction

        function void note_sample(logic [31:0] b);
            quant_result_t r;
            int            rows, cols;
            longint        idx;
            bit            row_end, last;
            rows = eff_count(row_count);
            cols = eff_count(column_count);
            r.quantized = 16'(quantise(fp32_value(b), fp32_value(scale_bits), narrow_mode));
            row_end = (src_col + 1) >= cols;
            last = row_end && (src_row + 1) >= rows;
            idx = transpose_on ? longint'(src_col) * rows + src_row
                               : longint'(src_row) * cols + src_col;
            r.dest_index = idx[19:0];
            r.last_element = last;
            expected_q.push_back(r);
            if (last)
            begin
                src_row = 0;
                src_col = 0;
            end
            else if (row_end)
            begin
                src_col = 0;
                src_row++;
            end
            else
                src_col++;
        endfunction

        function void check_result(logic signed [15:0] q, logic [19:0] di, logic le);
            quant_result_t r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result q=%0d idx=%0d last=%0b", $realtime, q, di, le);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (le)
                lasts++;
            if (q !== r.quantized)
            begin
                $display("%0t: quantized expected %0d actual %0d", $realtime, r.quantized, q);
                errors++;
            end
            if (di !== r.dest_index)
            begin
                $display("%0t: dest_index expected %0d actual %0d", $realtime, r.dest_index, di);
                errors++;
            end
            if (le !== r.last_element)
            begin
                $display("%0t: last_element expected %0b actual %0b", $realtime,
                         r.last_element, le);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        sample_bits;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] quantized;
    logic [19:0]        dest_index;
    logic               last_element;

    quant_scoreboard sb = new();
    int              sent;
    int              received;
    int              phases;
    bit              no_gaps;

    fp32_quantizer_with_transpose DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_bits  (sample_bits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .quantized    (quantized),
        .dest_index   (dest_index),
        .last_element (last_element)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(quantized, dest_index, last_element);
            received++;
        end

    // receiver: random stalls, one long hold-off while the sender keeps going
    initial
    begin
        int hold;
        out_ready = 1'b0;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold == 0 && received >= 300 && in_valid)
            begin
                out_ready = 1'b0;
                repeat (80) @(negedge clk);
                hold = 1;
            end
            if (no_gaps)
                out_ready = 1'b1;
            else
                out_ready = ($urandom_range(99) >= 28);
        end
    end

    task automatic send_sample(input logic [31:0] b);
        while (!no_gaps && $urandom_range(99) < 28)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample_bits = b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_sample(b);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [31:0] data);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.write_reg(idx, data);
    endtask

    function automatic logic [31:0] random_sample();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(9))
            0, 1:    ;
            2, 3, 4: b[30:23] = 8'($urandom_range(118, 142));
            5, 6:
            begin
                b[30:23] = 8'($urandom_range(120, 141));
                b[11:0] = 12'h0;
            end
            7:       b[30:23] = 8'($urandom_range(100, 160));
            8:       b[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
            default: b[30:0] = 31'h0;
        endcase
        return b;
    endfunction

    function automatic logic [31:0] random_scale();
        logic [31:0] s;
        s = $urandom;
        case ($urandom_range(11))
            0:       s = fqt_pkg::SCALE_RESET;
            1:       s = 32'h3F00_0000;
            2:       s = 32'h4380_0000;
            3:       s = 32'h7FC0_0000;
            4:       s = 32'h0000_0000;
            5:       s = 32'h7F80_0000;
            6:       s = 32'hFF7F_FFFF;
            7:       s = 32'h0000_0001;
            8:       s = 32'hFFFF_FFFF;
            default: s[30:23] = 8'($urandom_range(112, 140));
        endcase
        return s;
    endfunction

    function automatic logic [31:0] random_count();
        case ($urandom_range(11))
            0:       return 32'd0;
            1:       return 32'd1024;
            2:       return 32'h7FF;
            3:       return $urandom;
            4:       return 32'($urandom_range(1, 1024));
            default: return 32'($urandom_range(1, 8));
        endcase
    endfunction

    initial
    begin
        logic [31:0] corner[$];
        int          n;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = fqt_pkg::REG_SCALE;
        cfg_data = 32'h0;
        in_valid = 1'b0;
        sample_bits = 32'h0;
        no_gaps = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        corner = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                   32'h3F00_0000, 32'hBF00_0000, 32'h46FF_FE00, 32'h46FF_FECC,
                   32'h471C_4000, 32'hC71C_4000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'hFFC0_0000, 32'h0000_0001, 32'h8000_0001,
                   32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h4020_0000, 32'hC020_0000,
                   32'hFFFF_FFFF, 32'h4700_0000};
        // default 1x1 matrix, int16, then int8 with a 3x4 transposed shape
        foreach (corner[i])
            send_sample(corner[i]);
        write_cfg(fqt_pkg::REG_NARROW, 32'd1);
        write_cfg(fqt_pkg::REG_TRANSPOSE, 32'd1);
        write_cfg(fqt_pkg::REG_ROWS, 32'd3);
        write_cfg(fqt_pkg::REG_COLS, 32'd4);
        foreach (corner[i])
            send_sample(corner[i]);
        write_cfg(REG_SPARE, 32'hFFFF_FFFF);
        write_cfg(REG_HOLE, 32'd0);

        while (sent < N_ITEMS)
        begin
            phases++;
            write_cfg(fqt_pkg::REG_SCALE, random_scale());
            write_cfg(fqt_pkg::REG_NARROW, 32'($urandom_range(1)));
            write_cfg(fqt_pkg::REG_TRANSPOSE, 32'($urandom_range(1)));
            if ($urandom_range(3) != 0)
                write_cfg(fqt_pkg::REG_ROWS, random_count());
            if ($urandom_range(3) != 0)
                write_cfg(fqt_pkg::REG_COLS, random_count());
            n = $urandom_range(20, 90);
            no_gaps = (phases == 6);
            repeat (n)
                send_sample(random_sample());
            no_gaps = 1'b0;
        end
        in_valid = 1'b0;

        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        $display("run covered %0d samples and %0d results over %0d random phases",
                 sent, received, phases);
        $display("matrix end flags seen: %0d", sb.lasts);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
